// ===== design/sortpq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Request and status codes, field widths and the command and status
// structs that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package sortpq_pkg;

  localparam int REQ_W    = 2;
  localparam int VAL_W    = 32;
  localparam int IPRIO_W  = 8;
  localparam int STATUS_W = 2;
  localparam int FILL_W   = 5;

  localparam logic [REQ_W-1:0] REQ_ENQ  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_DEQ  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_PEEK = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic                load;
    logic                insert;
    logic                remove;
    logic                capture;
    logic                show_head;
    logic [STATUS_W-1:0] res_status;
  } sortpq_cmd_t;

  typedef struct packed {
    logic [REQ_W-1:0] req_code;
    logic             empty;
    logic             full;
  } sortpq_stat_t;

endpackage

// ===== design/sortpq_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted priority queue controller
// Steps each request through accept, execute and result hand-off, and
// decides the operation and status from the queue's empty and full flags.
// ----------------------------------------------------------------------------
module sortpq_ctrl
  import sortpq_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  logic         out_ready,
  input  sortpq_stat_t stat,
  output sortpq_cmd_t  cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_RESP = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_RESP);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.capture    = 1'b1;
        cmd.res_status = ST_OK;
        case (stat.req_code)
          REQ_ENQ: begin
            if (stat.full) begin
              cmd.res_status = ST_FULL;
            end else begin
              cmd.insert = 1'b1;
            end
          end
          REQ_DEQ: begin
            if (stat.empty) begin
              cmd.res_status = ST_EMPTY;
            end else begin
              cmd.remove    = 1'b1;
              cmd.show_head = 1'b1;
            end
          end
          REQ_PEEK: begin
            if (stat.empty) begin
              cmd.res_status = ST_EMPTY;
            end else begin
              cmd.show_head = 1'b1;
            end
          end
          default: begin
            cmd.res_status = ST_OK;
          end
        endcase
        state_next = S_RESP;
      end
      S_RESP: begin
        if (out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_insert_not_full: assert property (@(posedge clk) disable iff (rst)
    cmd.insert |-> !stat.full)
    else $error("insert issued while the queue is full");

  a_remove_not_empty: assert property (@(posedge clk) disable iff (rst)
    cmd.remove |-> !stat.empty)
    else $error("remove issued while the queue is empty");

  a_exec_then_resp: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (state == S_EXEC) ##1 out_valid)
    else $error("accepted item did not reach the result stage");

endmodule

// ===== design/sortpq_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted priority queue datapath
// A row of compare-and-shift cells kept in service order, the request
// register, the occupancy counter and the result register.
// ----------------------------------------------------------------------------
module sortpq_dp
  import sortpq_pkg::*;
#(
  parameter int DEPTH     = 16,
  parameter int PRIO_BITS = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [REQ_W-1:0]           req_type,
  input  logic signed [VAL_W-1:0]    item_value,
  input  logic [IPRIO_W-1:0]         item_priority,
  input  sortpq_cmd_t                cmd,
  output sortpq_stat_t               stat,
  output logic [STATUS_W-1:0]        status,
  output logic signed [VAL_W-1:0]    head_value,
  output logic [FILL_W-1:0]          fill_count
);

  localparam int OCC_W = $clog2(DEPTH + 1);
  localparam logic [OCC_W-1:0] OCC_MAX = OCC_W'(DEPTH);

  logic [REQ_W-1:0]     req_code;
  logic [VAL_W-1:0]     req_val;
  logic [PRIO_BITS-1:0] req_prio;

  logic [VAL_W-1:0]     vals  [DEPTH];
  logic [PRIO_BITS-1:0] prios [DEPTH];
  logic [DEPTH-1:0]     behind;

  logic [OCC_W-1:0] occ;
  logic [OCC_W-1:0] occ_next;

  assign stat.req_code = req_code;
  assign stat.empty    = (occ == '0);
  assign stat.full     = (occ == OCC_MAX);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_code <= req_type;
      req_val  <= item_value;
      req_prio <= PRIO_BITS'(item_priority);
    end
  end

  // A cell lies behind the new entry when it is empty or holds a larger
  // priority number; the new entry lands in the first such cell.
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    localparam logic [OCC_W-1:0] IDX = OCC_W'(k);

    assign behind[k] = (IDX >= occ) || (prios[k] > req_prio);

    always_ff @(posedge clk) begin
      if (cmd.insert && behind[k]) begin
        if (k == 0) begin
          vals[k]  <= req_val;
          prios[k] <= req_prio;
        end else if (!behind[(k == 0) ? 0 : k - 1]) begin
          vals[k]  <= req_val;
          prios[k] <= req_prio;
        end else begin
          vals[k]  <= vals[(k == 0) ? 0 : k - 1];
          prios[k] <= prios[(k == 0) ? 0 : k - 1];
        end
      end else if (cmd.remove && (k < DEPTH - 1)) begin
        vals[k]  <= vals[(k < DEPTH - 1) ? k + 1 : k];
        prios[k] <= prios[(k < DEPTH - 1) ? k + 1 : k];
      end
    end
  end

  always_comb begin
    occ_next = occ;
    if (cmd.insert) begin
      occ_next = occ + 1'b1;
    end else if (cmd.remove) begin
      occ_next = occ - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else begin
      occ <= occ_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      status     <= cmd.res_status;
      head_value <= cmd.show_head ? vals[0] : '0;
      fill_count <= FILL_W'(occ_next);
    end
  end

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= OCC_MAX)
    else $error("occupancy exceeds the queue depth");

  a_single_update: assert property (@(posedge clk) disable iff (rst)
    !(cmd.insert && cmd.remove))
    else $error("insert and remove issued together");

  a_head_sorted: assert property (@(posedge clk) disable iff (rst)
    (occ >= OCC_W'(2)) |-> (prios[0] <= prios[1]))
    else $error("head entries are out of priority order");

endmodule

// ===== design/sorted_priority_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted priority queue
// Bounded queue of DEPTH entries kept in priority order, smaller number
// first, with equal priorities served in arrival order.
// ----------------------------------------------------------------------------
// Each request (enqueue, dequeue or peek) passes through the controller's
// accept, execute and result states: accept takes it in, execute has every
// storage cell compare its priority with the new one and shift in parallel,
// and result presents the outcome, which then holds until it is taken. The
// next item is accepted in the cycle after the result is taken, so the queue
// takes no new item while one is still in execute or awaiting hand-off.
// Enqueue when full answers with a full status and changes nothing;
// dequeue or peek when empty answers with an empty status.
// ----------------------------------------------------------------------------
module sorted_priority_queue
  import sortpq_pkg::*;
#(
  parameter int DEPTH     = 16,
  parameter int PRIO_BITS = 8
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [REQ_W-1:0]        req_type,
  input  logic signed [VAL_W-1:0] item_value,
  input  logic [IPRIO_W-1:0]      item_priority,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [STATUS_W-1:0]     status,
  output logic signed [VAL_W-1:0] head_value,
  output logic [FILL_W-1:0]       fill_count
);

  sortpq_cmd_t  cmd;
  sortpq_stat_t stat;

  sortpq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  sortpq_dp #(
    .DEPTH     (DEPTH),
    .PRIO_BITS (PRIO_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .req_type      (req_type),
    .item_value    (item_value),
    .item_priority (item_priority),
    .cmd           (cmd),
    .stat          (stat),
    .status        (status),
    .head_value    (head_value),
    .fill_count    (fill_count)
  );

endmodule
